@@ design/fdsd_pkg.sv @@
// fdsd_pkg: shared types, codes and constants of the frame difference still detector
// no dependencies; used by scoped names in every design module but fdsd_chk
`default_nettype none

package fdsd_pkg;

    // register file
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned LUMA_W   = 24;
    localparam int unsigned FMT_W    = 2;
    localparam int unsigned ACT_W    = 16;
    localparam int unsigned MINRUN_W = 24;

    localparam logic [1:0] REG_LUMA_COUNT = 2'd0;
    localparam logic [1:0] REG_CHROMA_FMT = 2'd1;
    localparam logic [1:0] REG_THRESHOLD  = 2'd2;
    localparam logic [1:0] REG_MIN_STILL  = 2'd3;

    localparam logic [LUMA_W-1:0]   RST_LUMA_COUNT = 24'd2073600;
    localparam logic [FMT_W-1:0]    RST_CHROMA_FMT = 2'd0;
    localparam logic [ACT_W-1:0]    RST_THRESHOLD  = 16'd0;
    localparam logic [MINRUN_W-1:0] RST_MIN_STILL  = 24'd0;

    localparam logic [FMT_W-1:0] FMT_420 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_422 = 2'd1;

    // request codes
    localparam logic [1:0] MODE_PAIR  = 2'd0;
    localparam logic [1:0] MODE_LAST  = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    localparam logic [1:0] PLANE_Y  = 2'd0;
    localparam logic [1:0] PLANE_CB = 2'd1;
    localparam logic [1:0] PLANE_CR = 2'd2;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_EVENT  = 1'b1;

    // arithmetic
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned SUM_W    = 31;
    localparam int unsigned FRAME_W  = 32;
    localparam int unsigned FA_SUM_W = 19;
    localparam logic [SUM_W-1:0] SUM_MAX = 31'h7FFF_FFFF;
    localparam logic [ACT_W-1:0] ACT_MAX = 16'd65280;
    localparam int unsigned MAX_PIXELS_DEF = 8388608;

    // one quotient bit per step
    localparam int unsigned DIV_STEPS = ACT_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    typedef struct packed {
        logic [LUMA_W-1:0]   luma_count;
        logic [FMT_W-1:0]    chroma_fmt;
        logic [ACT_W-1:0]    threshold;
        logic [MINRUN_W-1:0] min_still;
    } t_cfg;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_LOAD   = 8'b0000_0010,
        ST_STEP   = 8'b0000_0100,
        ST_STORE  = 8'b0000_1000,
        ST_CALC   = 8'b0001_0000,
        ST_REPORT = 8'b0010_0000,
        ST_EVENT  = 8'b0100_0000,
        ST_FLUSH  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic       acc;          // add the accepted sample pair
        logic       div_load;     // set up the divider for one plane
        logic       div_step;     // one quotient bit
        logic       div_store;    // write the plane activity
        logic [1:0] plane;
        logic       calc_fa;      // weighted frame activity
        logic       load_report;  // report into the output register, run update
        logic       load_event;   // still event into the output register
        logic       frame_done;   // clear sums, advance frame counter
        logic       flush;        // back to the sequence start
    } t_cmd;

    typedef struct packed {
        logic ev_report;  // this frame closes a long enough run
        logic ev_flush;   // an open run is long enough at flush
    } t_sts;

endpackage

`default_nettype wire

@@ design/fdsd_regs.sv @@
// fdsd_regs: configuration registers behind the apb-style port
// depends on fdsd_pkg
`default_nettype none

module fdsd_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fdsd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [fdsd_pkg::DATA_W-1:0]  pwdata,
    output logic      [fdsd_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output fdsd_pkg::t_cfg                    o_cfg
);

    fdsd_pkg::t_cfg r_cfg;
    logic [1:0]     idx;
    logic           wr_en;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.luma_count <= fdsd_pkg::RST_LUMA_COUNT;
            r_cfg.chroma_fmt <= fdsd_pkg::RST_CHROMA_FMT;
            r_cfg.threshold  <= fdsd_pkg::RST_THRESHOLD;
            r_cfg.min_still  <= fdsd_pkg::RST_MIN_STILL;
        end else if (wr_en) begin
            unique case (idx)
                fdsd_pkg::REG_LUMA_COUNT: r_cfg.luma_count <= pwdata[fdsd_pkg::LUMA_W-1:0];
                fdsd_pkg::REG_CHROMA_FMT: r_cfg.chroma_fmt <= pwdata[fdsd_pkg::FMT_W-1:0];
                fdsd_pkg::REG_THRESHOLD:  r_cfg.threshold  <= pwdata[fdsd_pkg::ACT_W-1:0];
                fdsd_pkg::REG_MIN_STILL:  r_cfg.min_still  <= pwdata[fdsd_pkg::MINRUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            fdsd_pkg::REG_LUMA_COUNT: prdata = {8'd0, r_cfg.luma_count};
            fdsd_pkg::REG_CHROMA_FMT: prdata = {30'd0, r_cfg.chroma_fmt};
            fdsd_pkg::REG_THRESHOLD:  prdata = {16'd0, r_cfg.threshold};
            fdsd_pkg::REG_MIN_STILL:  prdata = {8'd0, r_cfg.min_still};
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ design/fdsd_ctrl.sv @@
// fdsd_ctrl: controller state machine, sequences division, report, event and flush
// depends on fdsd_pkg; drives fdsd_dp through t_cmd, reads t_sts
`default_nettype none

module fdsd_ctrl (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_mode,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  fdsd_pkg::t_sts  i_sts,
    output fdsd_pkg::t_cmd  o_cmd
);

    fdsd_pkg::t_state                r_state, n_state;
    logic [1:0]                      r_plane, n_plane;
    logic [fdsd_pkg::STEP_W-1:0]     r_step, n_step;
    logic                            r_out_valid, n_out_valid;
    logic                            slot_free;

    assign o_in_ready  = (r_state == fdsd_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign slot_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fdsd_pkg::ST_IDLE;
            r_plane     <= fdsd_pkg::PLANE_Y;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_plane     <= n_plane;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_plane     = r_plane;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.plane = r_plane;
        unique case (r_state)
            fdsd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_mode)
                        fdsd_pkg::MODE_PAIR: begin
                            o_cmd.acc = 1'b1;
                        end
                        fdsd_pkg::MODE_LAST: begin
                            o_cmd.acc = 1'b1;
                            n_plane   = fdsd_pkg::PLANE_Y;
                            n_state   = fdsd_pkg::ST_LOAD;
                        end
                        fdsd_pkg::MODE_FLUSH: begin
                            n_state = fdsd_pkg::ST_FLUSH;
                        end
                        default: ;
                    endcase
                end
            end
            fdsd_pkg::ST_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_step         = '0;
                n_state        = fdsd_pkg::ST_STEP;
            end
            fdsd_pkg::ST_STEP: begin
                o_cmd.div_step = 1'b1;
                if (r_step == fdsd_pkg::STEP_LAST) begin
                    n_state = fdsd_pkg::ST_STORE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            fdsd_pkg::ST_STORE: begin
                o_cmd.div_store = 1'b1;
                if (r_plane == fdsd_pkg::PLANE_CR) begin
                    n_state = fdsd_pkg::ST_CALC;
                end else begin
                    n_plane = r_plane + 1'b1;
                    n_state = fdsd_pkg::ST_LOAD;
                end
            end
            fdsd_pkg::ST_CALC: begin
                o_cmd.calc_fa = 1'b1;
                n_state       = fdsd_pkg::ST_REPORT;
            end
            fdsd_pkg::ST_REPORT: begin
                if (slot_free) begin
                    o_cmd.load_report = 1'b1;
                    n_out_valid       = 1'b1;
                    if (i_sts.ev_report) begin
                        n_state = fdsd_pkg::ST_EVENT;
                    end else begin
                        o_cmd.frame_done = 1'b1;
                        n_state          = fdsd_pkg::ST_IDLE;
                    end
                end
            end
            fdsd_pkg::ST_EVENT: begin
                if (slot_free) begin
                    o_cmd.load_event = 1'b1;
                    o_cmd.frame_done = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = fdsd_pkg::ST_IDLE;
                end
            end
            fdsd_pkg::ST_FLUSH: begin
                if (!i_sts.ev_flush) begin
                    o_cmd.flush = 1'b1;
                    n_state     = fdsd_pkg::ST_IDLE;
                end else if (slot_free) begin
                    o_cmd.load_event = 1'b1;
                    o_cmd.flush      = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = fdsd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fdsd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/fdsd_dp.sv @@
// fdsd_dp: sums, bit-serial divider, run tracking and output register
// depends on fdsd_pkg; commanded by fdsd_ctrl
`default_nettype none

module fdsd_dp #(
    parameter int unsigned MAX_PIXELS = fdsd_pkg::MAX_PIXELS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  fdsd_pkg::t_cfg                       i_cfg,
    input  fdsd_pkg::t_cmd                       i_cmd,
    output fdsd_pkg::t_sts                       o_sts,
    input  wire logic [1:0]                      i_plane,
    input  wire logic [fdsd_pkg::SAMPLE_W-1:0]   i_cur_sample,
    input  wire logic [fdsd_pkg::SAMPLE_W-1:0]   i_prev_sample,
    output logic                                 o_kind,
    output logic [fdsd_pkg::FRAME_W-1:0]         o_frame_index,
    output logic [fdsd_pkg::ACT_W-1:0]           o_luma_act,
    output logic [fdsd_pkg::ACT_W-1:0]           o_cb_act,
    output logic [fdsd_pkg::ACT_W-1:0]           o_cr_act,
    output logic [fdsd_pkg::ACT_W-1:0]           o_frame_act,
    output logic                                 o_still_flag,
    output logic [fdsd_pkg::FRAME_W-1:0]         o_scene_start,
    output logic [fdsd_pkg::FRAME_W-1:0]         o_scene_end,
    output logic                                 o_last
);

    localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int unsigned SUM_W = fdsd_pkg::SUM_W;
    localparam int unsigned ACT_W = fdsd_pkg::ACT_W;
    localparam int unsigned FR_W  = fdsd_pkg::FRAME_W;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [fdsd_pkg::SAMPLE_W-1:0] d);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {{(SUM_W + 1 - fdsd_pkg::SAMPLE_W){1'b0}}, d};
        return (t > {1'b0, fdsd_pkg::SUM_MAX}) ? fdsd_pkg::SUM_MAX : t[SUM_W-1:0];
    endfunction

    // frame state
    logic [SUM_W-1:0] r_y_sum, r_cb_sum, r_cr_sum;
    logic [FR_W-1:0]  r_frame_cnt, r_run_len, r_run_first;
    logic             r_in_run;

    // divider
    logic [CNT_W-1:0] r_rem, r_div_cnt;
    logic [ACT_W-1:0] r_quo, r_dvd;
    logic             r_div_zero, r_div_sat;

    // activities
    logic [ACT_W-1:0] r_ya, r_cba, r_cra, r_fa;

    logic [fdsd_pkg::SAMPLE_W-1:0] diff;
    logic [CNT_W-1:0]              luma_cnt, chroma_cnt, sel_cnt;
    logic [SUM_W-1:0]              sel_sum;
    logic [FR_W-1:0]               sum_hi;
    logic [CNT_W:0]                rem_sh;
    logic                          rem_ge;
    logic [ACT_W-1:0]              div_res;
    logic [fdsd_pkg::FA_SUM_W-1:0] fa_sum;
    logic                          still, run_long, next_in_run;
    logic [FR_W-1:0]               end_frame;

    assign diff = (i_cur_sample >= i_prev_sample) ? i_cur_sample - i_prev_sample
                                                  : i_prev_sample - i_cur_sample;

    // clamped luma count and the chroma count that follows from it
    assign luma_cnt = ({8'd0, i_cfg.luma_count} > FR_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS)
                                                                     : CNT_W'(i_cfg.luma_count);
    always_comb begin
        case (i_cfg.chroma_fmt)
            fdsd_pkg::FMT_420: chroma_cnt = luma_cnt >> 2;
            fdsd_pkg::FMT_422: chroma_cnt = luma_cnt >> 1;
            default:           chroma_cnt = luma_cnt;
        endcase
    end

    always_comb begin
        case (i_cmd.plane)
            fdsd_pkg::PLANE_Y:  sel_sum = r_y_sum;
            fdsd_pkg::PLANE_CB: sel_sum = r_cb_sum;
            default:            sel_sum = r_cr_sum;
        endcase
    end
    assign sel_cnt = (i_cmd.plane == fdsd_pkg::PLANE_Y) ? luma_cnt : chroma_cnt;
    assign sum_hi  = {1'b0, sel_sum} >> 8;

    assign rem_sh = {r_rem, r_dvd[ACT_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_div_cnt};

    always_comb begin
        if (r_div_zero) begin
            div_res = '0;
        end else if (r_div_sat || r_quo > fdsd_pkg::ACT_MAX) begin
            div_res = fdsd_pkg::ACT_MAX;
        end else begin
            div_res = r_quo;
        end
    end

    assign fa_sum = ({3'd0, r_ya} << 2) + ({3'd0, r_ya} << 1) + {3'd0, r_cba} + {3'd0, r_cra};

    assign still       = r_fa <= i_cfg.threshold;
    assign run_long    = r_run_len > {8'd0, i_cfg.min_still};
    assign next_in_run = still;
    assign end_frame   = r_frame_cnt - 1'b1;

    assign o_sts.ev_report = !still && r_in_run && run_long;
    assign o_sts.ev_flush  = r_in_run && run_long;

    // divider: one quotient bit per step, remainder stays below the count unless the result saturates
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div_zero <= (sel_cnt == '0);
            r_div_sat  <= sum_hi >= FR_W'(sel_cnt);
            r_rem      <= CNT_W'(sum_hi);
            r_dvd      <= {sel_sum[7:0], 8'd0};
            r_div_cnt  <= sel_cnt;
            r_quo      <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? CNT_W'(rem_sh - {1'b0, r_div_cnt}) : rem_sh[CNT_W-1:0];
            r_quo <= {r_quo[ACT_W-2:0], rem_ge};
            r_dvd <= r_dvd << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            case (i_cmd.plane)
                fdsd_pkg::PLANE_Y:  r_ya  <= div_res;
                fdsd_pkg::PLANE_CB: r_cba <= div_res;
                default:            r_cra <= div_res;
            endcase
        end
        if (i_cmd.calc_fa) begin
            r_fa <= fa_sum[fdsd_pkg::FA_SUM_W-1:3];
        end
    end

    // sums, frame counter and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_sum     <= '0;
            r_cb_sum    <= '0;
            r_cr_sum    <= '0;
            r_frame_cnt <= FR_W'(1);
            r_in_run    <= 1'b0;
            r_run_len   <= '0;
            r_run_first <= '0;
        end else if (i_cmd.flush) begin
            r_y_sum     <= '0;
            r_cb_sum    <= '0;
            r_cr_sum    <= '0;
            r_frame_cnt <= FR_W'(1);
            r_in_run    <= 1'b0;
            r_run_len   <= '0;
            r_run_first <= '0;
        end else begin
            if (i_cmd.acc) begin
                case (i_plane)
                    fdsd_pkg::PLANE_Y:  r_y_sum  <= sat_add(r_y_sum, diff);
                    fdsd_pkg::PLANE_CB: r_cb_sum <= sat_add(r_cb_sum, diff);
                    fdsd_pkg::PLANE_CR: r_cr_sum <= sat_add(r_cr_sum, diff);
                    default: ;
                endcase
            end
            if (i_cmd.load_report) begin
                if (still) begin
                    if (r_run_len != '1) begin
                        r_run_len <= r_run_len + 1'b1;
                    end
                    if (!r_in_run) begin
                        r_in_run    <= 1'b1;
                        r_run_first <= r_frame_cnt;
                    end
                end else if (r_in_run) begin
                    r_in_run  <= 1'b0;
                    r_run_len <= '0;
                end
            end
            if (i_cmd.frame_done) begin
                r_y_sum     <= '0;
                r_cb_sum    <= '0;
                r_cr_sum    <= '0;
                r_frame_cnt <= r_frame_cnt + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_report) begin
            o_kind        <= fdsd_pkg::KIND_REPORT;
            o_frame_index <= r_frame_cnt;
            o_luma_act    <= r_ya;
            o_cb_act      <= r_cba;
            o_cr_act      <= r_cra;
            o_frame_act   <= r_fa;
            o_still_flag  <= next_in_run;
            o_scene_start <= '0;
            o_scene_end   <= '0;
            o_last        <= !o_sts.ev_report;
        end else if (i_cmd.load_event) begin
            o_kind        <= fdsd_pkg::KIND_EVENT;
            o_frame_index <= end_frame;
            o_luma_act    <= '0;
            o_cb_act      <= '0;
            o_cr_act      <= '0;
            o_frame_act   <= '0;
            o_still_flag  <= 1'b0;
            o_scene_start <= r_run_first;
            o_scene_end   <= end_frame;
            o_last        <= 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ design/frame_difference_still_detector_unit.sv @@
// frame_difference_still_detector_unit: top level of the still scene detector
// depends on fdsd_pkg, fdsd_regs, fdsd_ctrl, fdsd_dp
// sequence: a sample pair request is taken and gives no result; a frame-end request gives
//   its report once the three planes are divided in turn (load, steps, store) and the
//   frame activity is computed, and any still event comes as soon as the report is taken
// throughput: one sample pair per cycle while idle; a frame end blocks new requests until
//   it is done, bound by the single bit-serial divider shared by the three planes
// reset: synchronous active low, clears control, sums and run state, loads register defaults
`default_nettype none

module frame_difference_still_detector_unit #(
    parameter int unsigned MAX_PIXELS = fdsd_pkg::MAX_PIXELS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [1:0]                     i_mode,
    input  wire logic [1:0]                     i_plane,
    input  wire logic [fdsd_pkg::SAMPLE_W-1:0]  i_cur_sample,
    input  wire logic [fdsd_pkg::SAMPLE_W-1:0]  i_prev_sample,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_kind,
    output logic [fdsd_pkg::FRAME_W-1:0]        o_frame_index,
    output logic [fdsd_pkg::ACT_W-1:0]          o_luma_act,
    output logic [fdsd_pkg::ACT_W-1:0]          o_cb_act,
    output logic [fdsd_pkg::ACT_W-1:0]          o_cr_act,
    output logic [fdsd_pkg::ACT_W-1:0]          o_frame_act,
    output logic                                o_still_flag,
    output logic [fdsd_pkg::FRAME_W-1:0]        o_scene_start,
    output logic [fdsd_pkg::FRAME_W-1:0]        o_scene_end,
    output logic                                o_last,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fdsd_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [fdsd_pkg::DATA_W-1:0]    pwdata,
    output logic      [fdsd_pkg::DATA_W-1:0]    prdata,
    output logic                                pready
);

    fdsd_pkg::t_cfg cfg;
    fdsd_pkg::t_cmd cmd;
    fdsd_pkg::t_sts sts;

    // luma count, chroma format, threshold and minimum run length
    fdsd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencing: request acceptance, per plane division, report then event
    fdsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_mode      (i_mode),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // sums, divider, run tracking; the output register lets a report with no event after it
    // wait while further sample pairs keep streaming in
    fdsd_dp #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_plane       (i_plane),
        .i_cur_sample  (i_cur_sample),
        .i_prev_sample (i_prev_sample),
        .o_kind        (o_kind),
        .o_frame_index (o_frame_index),
        .o_luma_act    (o_luma_act),
        .o_cb_act      (o_cb_act),
        .o_cr_act      (o_cr_act),
        .o_frame_act   (o_frame_act),
        .o_still_flag  (o_still_flag),
        .o_scene_start (o_scene_start),
        .o_scene_end   (o_scene_end),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

@@ design/fdsd_chk.sv @@
// fdsd_chk: port-level checker for the still scene detector, bound to the top level
// depends on the port list of frame_difference_still_detector_unit
`default_nettype none

module fdsd_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_kind,
    input wire logic [31:0] o_frame_index,
    input wire logic [15:0] o_luma_act,
    input wire logic [15:0] o_frame_act,
    input wire logic [31:0] o_scene_end,
    input wire logic        o_last
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // report without last is followed directly by its still event
    a_event_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && (o_kind == 1'b0) && !o_last |=> o_valid && (o_kind == 1'b1))
        else $error("missing still event after report");

    // still events close the request and carry the run end as frame index
    a_event_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == 1'b1) |-> o_last && (o_scene_end == o_frame_index)
                                        && (o_luma_act == 16'd0))
        else $error("malformed still event");

    // activities saturate at 255.0
    a_act_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == 1'b0) |-> (o_luma_act <= 16'd65280)
                                        && (o_frame_act <= 16'd65280))
        else $error("activity above saturation");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind frame_difference_still_detector_unit fdsd_chk u_fdsd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_kind        (o_kind),
    .o_frame_index (o_frame_index),
    .o_luma_act    (o_luma_act),
    .o_frame_act   (o_frame_act),
    .o_scene_end   (o_scene_end),
    .o_last        (o_last)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench of frame_difference_still_detector_unit
// depends on fdsd_pkg and the unit; drives requests and register writes, predicts every
// activity report and still scene event, and checks them in order on the result channel
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fdsd_pkg::*;

    localparam int unsigned CLK_PERIOD     = 20;
    localparam int unsigned RESET_CYCLES   = 9;
    localparam longint      TIMEOUT_NS     = 10_000_000;
    // room for a frame end to reach its report, with margin on top
    localparam int unsigned SETTLE_CYCLES  = 80;
    localparam int unsigned PHASE_REQUESTS = 165;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned PRESSURE_PHASE = 5;
    localparam int unsigned MAX_PIXELS     = MAX_PIXELS_DEF;

    // codes the package leaves unnamed
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam logic [1:0] PLANE_UNUSED = 2'd3;
    localparam logic [1:0] FMT_444      = 2'd2;
    localparam logic [1:0] FMT_UNUSED   = 2'd3;

    // luma twice as likely as either chroma plane
    localparam logic [1:0] PLANE_PICK [4] = '{PLANE_Y, PLANE_Y, PLANE_CB, PLANE_CR};

    // register settings of the random phases: luma count, chroma format, threshold, min run
    localparam t_cfg RANDOM_SETTINGS [6] = '{
        '{24'd8,    FMT_420,    16'h0800, 24'd0},
        '{24'd16,   FMT_422,    16'h2000, 24'd2},
        '{24'd6,    FMT_444,    16'h1000, 24'd1},
        '{24'd12,   FMT_UNUSED, 16'hFFC0, 24'd3},
        '{24'd2,    FMT_420,    16'h4000, 24'd0},
        '{24'd1000, FMT_422,    16'h0100, 24'd0}
    };

    typedef struct packed {
        logic        kind;
        logic [31:0] frame_index;
        logic [15:0] luma_act;
        logic [15:0] cb_act;
        logic [15:0] cr_act;
        logic [15:0] frame_act;
        logic        still;
        logic [31:0] scene_start;
        logic [31:0] scene_end;
        logic        last;
    } t_report;

    // one line of stimulus: a register write or a request
    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_index;
        logic [31:0] reg_value;
        logic [1:0]  mode;
        logic [1:0]  plane;
        logic [7:0]  cur_sample;
        logic [7:0]  prev_sample;
        int          typed_count;   // -1: results come from the predictor
        t_report     typed_first;
        t_report     typed_second;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_mode;
    logic [1:0]  i_plane;
    logic [7:0]  i_cur_sample;
    logic [7:0]  i_prev_sample;
    logic        o_valid;
    logic        i_ready;
    logic        o_kind;
    logic [31:0] o_frame_index;
    logic [15:0] o_luma_act;
    logic [15:0] o_cb_act;
    logic [15:0] o_cr_act;
    logic [15:0] o_frame_act;
    logic        o_still_flag;
    logic [31:0] o_scene_start;
    logic [31:0] o_scene_end;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    // predictor state, mirrors the block after each accepted request
    t_cfg        cfg_model;
    logic [30:0] luma_sum;
    logic [30:0] cb_sum;
    logic [30:0] cr_sum;
    logic [31:0] frame_count;
    logic        in_still_run;
    logic [31:0] still_run_len;
    logic [31:0] still_run_first;

    t_report     pending_reports[$];
    int          mismatch_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          ready_hold_left;

    frame_difference_still_detector_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_plane       (i_plane),
        .i_cur_sample  (i_cur_sample),
        .i_prev_sample (i_prev_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_frame_index (o_frame_index),
        .o_luma_act    (o_luma_act),
        .o_cb_act      (o_cb_act),
        .o_cr_act      (o_cr_act),
        .o_frame_act   (o_frame_act),
        .o_still_flag  (o_still_flag),
        .o_scene_start (o_scene_start),
        .o_scene_end   (o_scene_end),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // hard stop in case a result never shows up
    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic t_report report_of(input logic [31:0] frame, input logic [15:0] y_act,
            input logic [15:0] cb_in, input logic [15:0] cr_in, input logic [15:0] fa,
            input logic still, input logic last);
        t_report r;
        r = '0;
        r.kind        = KIND_REPORT;
        r.frame_index = frame;
        r.luma_act    = y_act;
        r.cb_act      = cb_in;
        r.cr_act      = cr_in;
        r.frame_act   = fa;
        r.still       = still;
        r.last        = last;
        return r;
    endfunction

    // a still scene event is always the final result of its request
    function automatic t_report event_of(input logic [31:0] run_start, input logic [31:0] run_stop);
        t_report r;
        r = '0;
        r.kind        = KIND_EVENT;
        r.frame_index = run_stop;
        r.scene_start = run_start;
        r.scene_end   = run_stop;
        r.last        = 1'b1;
        return r;
    endfunction

    function automatic logic [30:0] saturate_sum(input logic [30:0] sum, input logic [7:0] diff);
        logic [31:0] total;
        total = 32'(sum) + 32'(diff);
        return (total > 32'(SUM_MAX)) ? SUM_MAX : total[30:0];
    endfunction

    function automatic void add_difference(input logic [1:0] plane, input logic [7:0] cur,
            input logic [7:0] prev);
        logic [7:0] diff;
        diff = (cur >= prev) ? cur - prev : prev - cur;
        case (plane)
            PLANE_Y:  luma_sum = saturate_sum(luma_sum, diff);
            PLANE_CB: cb_sum   = saturate_sum(cb_sum, diff);
            PLANE_CR: cr_sum   = saturate_sum(cr_sum, diff);
            default: ;  // unused plane code, pair is dropped
        endcase
    endfunction

    // mean absolute difference in unsigned Q8.8, floored and saturated
    function automatic logic [15:0] mean_q88(input logic [30:0] sum, input logic [23:0] count);
        logic [63:0] quotient;
        if (count == '0) return '0;
        quotient = (64'(sum) << 8) / 64'(count);
        return (quotient > 64'(ACT_MAX)) ? ACT_MAX : quotient[15:0];
    endfunction

    function automatic void clear_sequence_state();
        luma_sum        = '0;
        cb_sum          = '0;
        cr_sum          = '0;
        frame_count     = 32'd1;
        in_still_run    = 1'b0;
        still_run_len   = '0;
        still_run_first = '0;
    endfunction

    // advances the model by one request, returns how many results it causes
    function automatic int predict_frame_step(input logic [1:0] mode, input logic [1:0] plane,
            input logic [7:0] cur, input logic [7:0] prev,
            output t_report first, output t_report second);
        logic [23:0] luma_n;
        logic [23:0] chroma_n;
        logic [15:0] ya;
        logic [15:0] cba;
        logic [15:0] cra;
        logic [15:0] fa;
        logic [31:0] weighted;
        int          n;
        first  = '0;
        second = '0;
        n      = 0;
        if (mode == MODE_PAIR) begin
            add_difference(plane, cur, prev);
            return 0;
        end
        if (mode == MODE_FLUSH) begin
            if (in_still_run && still_run_len > 32'(cfg_model.min_still)) begin
                first = event_of(still_run_first, frame_count - 32'd1);
                n     = 1;
            end
            clear_sequence_state();
            return n;
        end
        if (mode != MODE_LAST) return 0;

        add_difference(plane, cur, prev);
        luma_n = (cfg_model.luma_count > 24'(MAX_PIXELS)) ? 24'(MAX_PIXELS)
                                                          : cfg_model.luma_count;
        case (cfg_model.chroma_fmt)
            FMT_420: chroma_n = luma_n >> 2;
            FMT_422: chroma_n = luma_n >> 1;
            default: chroma_n = luma_n;
        endcase
        ya       = mean_q88(luma_sum, luma_n);
        cba      = mean_q88(cb_sum, chroma_n);
        cra      = mean_q88(cr_sum, chroma_n);
        weighted = 6 * 32'(ya) + 32'(cba) + 32'(cra);
        fa       = weighted[18:3];
        first    = report_of(frame_count, ya, cba, cra, fa, 1'b0, 1'b0);
        n        = 1;

        if (fa <= cfg_model.threshold) begin
            if (still_run_len != '1) still_run_len++;
            if (!in_still_run) begin
                in_still_run    = 1'b1;
                still_run_first = frame_count;
            end
        end else if (in_still_run) begin
            if (still_run_len > 32'(cfg_model.min_still)) begin
                second = event_of(still_run_first, frame_count - 32'd1);
                n      = 2;
            end
            in_still_run  = 1'b0;
            still_run_len = '0;
        end
        first.still = in_still_run;
        first.last  = (n == 1);

        luma_sum = '0;
        cb_sum   = '0;
        cr_sum   = '0;
        frame_count++;
        return n;
    endfunction

    // ---------------------------------------------------------------- stimulus rows

    function automatic t_stim_row req_row(input logic [1:0] mode, input logic [1:0] plane,
            input logic [7:0] cur, input logic [7:0] prev);
        t_stim_row row;
        row             = '{default: '0};
        row.mode        = mode;
        row.plane       = plane;
        row.cur_sample  = cur;
        row.prev_sample = prev;
        row.typed_count = -1;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [1:0] index, input logic [31:0] value);
        t_stim_row row;
        row           = req_row(MODE_PAIR, PLANE_Y, '0, '0);
        row.is_cfg    = 1'b1;
        row.reg_index = index;
        row.reg_value = value;
        return row;
    endfunction

    // request whose results are read straight off the spec
    function automatic t_stim_row expecting(input t_stim_row row, input int n,
            input t_report r0, input t_report r1);
        row.typed_count  = n;
        row.typed_first  = r0;
        row.typed_second = r1;
        return row;
    endfunction

    // quiet pairs differ by at most 3 so frames tend to fall under the threshold
    function automatic t_stim_row random_request(input logic [1:0] mode, input bit quiet);
        logic [7:0] cur;
        logic [1:0] plane;
        cur   = 8'($urandom);
        plane = ($urandom_range(0, 19) == 0) ? PLANE_UNUSED : PLANE_PICK[$urandom_range(0, 3)];
        return req_row(mode, plane, cur, quiet ? cur ^ 8'($urandom_range(0, 3)) : 8'($urandom));
    endfunction

    // ---------------------------------------------------------------- drivers

    // valid stays high from one request to the next unless a gap is drawn
    task automatic offer_request(input t_stim_row row);
        t_report first;
        t_report second;
        int      n;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_valid       <= 1'b1;
        i_mode        <= row.mode;
        i_plane       <= row.plane;
        i_cur_sample  <= row.cur_sample;
        i_prev_sample <= row.prev_sample;
        do @(posedge i_clk); while (!o_ready);
        // accepted at this edge
        n = predict_frame_step(row.mode, row.plane, row.cur_sample, row.prev_sample,
                               first, second);
        if (row.typed_count >= 0) begin
            n      = row.typed_count;
            first  = row.typed_first;
            second = row.typed_second;
        end
        if (n > 0) pending_reports.push_back(first);
        if (n > 1) pending_reports.push_back(second);
    endtask

    // drops valid and waits for a clock edge first, so valid is never driven twice in one step
    task automatic pause_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    // a pair request or a flush may still be in flight with nothing expected
    task automatic drain_pipeline();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup cycle, then access cycle; the register takes the data at the access edge
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_LUMA_COUNT: cfg_model.luma_count = value[LUMA_W-1:0];
            REG_CHROMA_FMT: cfg_model.chroma_fmt = value[FMT_W-1:0];
            REG_THRESHOLD:  cfg_model.threshold  = value[ACT_W-1:0];
            REG_MIN_STILL:  cfg_model.min_still  = value[MINRUN_W-1:0];
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- result side

    // random back pressure, or a long hold-off when the stimulus asks for one
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_hold_left != 0) begin
                i_ready <= 1'b0;
                ready_hold_left--;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
            input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // every accepted result is matched against the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_report want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kind %0d frame %0d",
                         $time, o_kind, o_frame_index);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("frame_index", want.frame_index, o_frame_index);
                check_field("luma_act", 32'(want.luma_act), 32'(o_luma_act));
                check_field("cb_act", 32'(want.cb_act), 32'(o_cb_act));
                check_field("cr_act", 32'(want.cr_act), 32'(o_cr_act));
                check_field("frame_act", 32'(want.frame_act), 32'(o_frame_act));
                check_field("still_flag", 32'(want.still), 32'(o_still_flag));
                check_field("scene_start", want.scene_start, o_scene_start);
                check_field("scene_end", want.scene_end, o_scene_end);
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        t_stim_row directed_rows[$];
        t_cfg      setting;
        int        counted;
        int        pairs;
        bit        quiet;
        bit        hold_done;

        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_mode          <= MODE_PAIR;
        i_plane         <= PLANE_Y;
        i_cur_sample    <= '0;
        i_prev_sample   <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        mismatch_count  = 0;
        ready_hold_left = 0;
        hold_done       = 1'b0;
        // first idling stage: sender mostly busy, receiver mostly stalled
        tx_idle_pct     = 16;
        rx_idle_pct     = 82;
        cfg_model       = '{RST_LUMA_COUNT, RST_CHROMA_FMT, RST_THRESHOLD, RST_MIN_STILL};
        clear_sequence_state();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset values, zero chroma count, saturation, unused codes, run end,
        // register extremes, luma clamp, unused chroma format
        directed_rows = '{
            // all-zero frame at reset config is still, flush closes the one-frame run
            expecting(req_row(MODE_LAST, PLANE_Y, 8'd0, 8'd0), 1,
                      report_of(32'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1), '0),
            expecting(req_row(MODE_FLUSH, PLANE_Y, 8'd0, 8'd0), 1, event_of(32'd1, 32'd1), '0),
            cfg_row(REG_LUMA_COUNT, 32'd1),
            cfg_row(REG_CHROMA_FMT, 32'(FMT_420)),
            // one luma sample: mean of 510 saturates, chroma count floors to zero
            req_row(MODE_PAIR, PLANE_Y, 8'd255, 8'd0),
            expecting(req_row(MODE_LAST, PLANE_Y, 8'd0, 8'd255), 1,
                      report_of(32'd1, ACT_MAX, 16'd0, 16'd0, 16'd48960, 1'b0, 1'b1), '0),
            req_row(MODE_PAIR, PLANE_CB, 8'd255, 8'd0),
            req_row(MODE_PAIR, PLANE_CR, 8'd0, 8'd255),
            // unused plane on the frame end: pair dropped, report still comes
            expecting(req_row(MODE_LAST, PLANE_UNUSED, 8'd170, 8'd85), 1,
                      report_of(32'd2, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1), '0),
            req_row(MODE_UNUSED, PLANE_UNUSED, 8'd255, 8'd255),
            // busy frame ends the run: report then event
            expecting(req_row(MODE_LAST, PLANE_Y, 8'd200, 8'd100), 2,
                      report_of(32'd3, 16'd25600, 16'd0, 16'd0, 16'd19200, 1'b0, 1'b0),
                      event_of(32'd2, 32'd2)),
            cfg_row(REG_THRESHOLD, 32'hFFFF),
            cfg_row(REG_MIN_STILL, 32'hFF_FFFF),
            cfg_row(REG_CHROMA_FMT, 32'(FMT_444)),
            cfg_row(REG_LUMA_COUNT, 32'd4),
            req_row(MODE_PAIR, PLANE_CB, 8'd255, 8'd0),
            req_row(MODE_LAST, PLANE_CR, 8'd0, 8'd255),
            // run too short for the largest minimum, flush gives nothing
            req_row(MODE_FLUSH, PLANE_CB, 8'd0, 8'd0),
            cfg_row(REG_CHROMA_FMT, 32'(FMT_UNUSED)),
            cfg_row(REG_LUMA_COUNT, 32'hFF_FFFF),
            cfg_row(REG_THRESHOLD, 32'd0),
            cfg_row(REG_MIN_STILL, 32'd0),
            req_row(MODE_PAIR, PLANE_Y, 8'd255, 8'd0),
            req_row(MODE_LAST, PLANE_Y, 8'd255, 8'd0),
            cfg_row(REG_CHROMA_FMT, 32'(FMT_422)),
            cfg_row(REG_LUMA_COUNT, 32'd3),
            req_row(MODE_PAIR, PLANE_CB, 8'd255, 8'd0),
            req_row(MODE_LAST, PLANE_CR, 8'd255, 8'd0),
            req_row(MODE_FLUSH, PLANE_CR, 8'd255, 8'd255)
        };

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                drain_pipeline();
                write_register(directed_rows[k].reg_index, directed_rows[k].reg_value);
            end else begin
                offer_request(directed_rows[k]);
            end
        end

        // random frames: well formed mostly, with flushes mid-frame and unused codes
        foreach (RANDOM_SETTINGS[ph]) begin
            if (ph == 2) begin
                tx_idle_pct = 82;
                rx_idle_pct = 16;
            end else if (ph == 4) begin
                // no idling from here on
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            setting = RANDOM_SETTINGS[ph];
            drain_pipeline();
            write_register(REG_LUMA_COUNT, 32'(setting.luma_count));
            write_register(REG_CHROMA_FMT, 32'(setting.chroma_fmt));
            write_register(REG_THRESHOLD, 32'(setting.threshold));
            write_register(REG_MIN_STILL, 32'(setting.min_still));

            counted = 0;
            while (counted < PHASE_REQUESTS) begin
                quiet = ($urandom_range(0, 99) < 60);
                pairs = $urandom_range(0, 9);
                repeat (pairs) begin
                    if ($urandom_range(0, 29) == 0)
                        offer_request(random_request(MODE_UNUSED, quiet));
                    if ($urandom_range(0, 79) == 0) begin
                        offer_request(random_request(MODE_FLUSH, quiet));
                        counted++;
                    end
                    offer_request(random_request(MODE_PAIR, quiet));
                    counted++;
                end
                // sender waits for every outstanding result now and then
                if ($urandom_range(0, 24) == 0) pause_until_drained();
                offer_request(random_request(MODE_LAST, quiet));
                counted++;
                // long receiver hold-off while frame ends keep coming, fills the block
                if (ph == PRESSURE_PHASE && !hold_done && counted > 40) begin
                    ready_hold_left = HOLD_CYCLES;
                    hold_done       = 1'b1;
                end
                if ($urandom_range(0, 9) == 0) begin
                    offer_request(random_request(MODE_FLUSH, quiet));
                    counted++;
                end
            end
        end

        drain_pipeline();
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
